/* hdl/tfn_pkg.sv */
// Shared word types and fixed constants for the triangle face normal core.
package tfn_pkg;

	localparam int IN_BITS  = 16;
	localparam int OUT_BITS = 16;

	typedef logic [1:0] copy_t;

	localparam copy_t FIRST_COPY = 2'd0;
	localparam copy_t LAST_COPY  = 2'd2;

	typedef struct packed {
		logic signed [IN_BITS-1:0] v0_x;
		logic signed [IN_BITS-1:0] v0_y;
		logic signed [IN_BITS-1:0] v0_z;
		logic signed [IN_BITS-1:0] v1_x;
		logic signed [IN_BITS-1:0] v1_y;
		logic signed [IN_BITS-1:0] v1_z;
		logic signed [IN_BITS-1:0] v2_x;
		logic signed [IN_BITS-1:0] v2_y;
		logic signed [IN_BITS-1:0] v2_z;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] x;
		logic signed [OUT_BITS-1:0] y;
		logic signed [OUT_BITS-1:0] z;
	} normal_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] normal_x;
		logic signed [OUT_BITS-1:0] normal_y;
		logic signed [OUT_BITS-1:0] normal_z;
		logic                       last;
	} out_word_t;

endpackage

/* hdl/triangle_face_normal_core.sv */
// Top level of the triangle face normal core: datapath pipeline and three-copy output stage.
// One triangle word in gives three normal words out, the third flagged last. The output
// channel moves one word per cycle while nrm_stall is low, and a new normal enters the copy
// register only when it is empty or its last copy is taken; the arithmetic pipeline can take
// a triangle each cycle unless it stalls behind the copy register, and holds
// 6 + (2*COORD_BITS+3) + (NORMAL_FRAC_BITS+1) + 1 stages (the square root retires one result
// bit per stage, the division one quotient bit per stage).
module triangle_face_normal_core import tfn_pkg::*; #(
	parameter int COORD_BITS       = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tri_valid,
	output logic      tri_stall,
	input  in_word_t  tri_word,
	output logic      nrm_valid,
	input  logic      nrm_stall,
	output out_word_t nrm_word
);

	logic    dp_valid;
	normal_t dp_normal;
	logic    adv;
	logic    load;
	logic    done;

	logic    hold_q;
	copy_t   cnt_q;
	normal_t nrm_q;

	tfn_datapath #(
		.COORD_BITS       (COORD_BITS),
		.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (tri_valid),
		.in_word    (tri_word),
		.out_valid  (dp_valid),
		.out_normal (dp_normal)
	);

	assign done      = hold_q && !nrm_stall && (cnt_q == LAST_COPY);
	assign load      = dp_valid && (!hold_q || done);
	assign adv       = !dp_valid || load;
	assign tri_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			cnt_q  <= FIRST_COPY;
		end else if (load) begin
			hold_q <= 1'b1;
			cnt_q  <= FIRST_COPY;
		end else if (done) begin
			hold_q <= 1'b0;
			cnt_q  <= FIRST_COPY;
		end else if (hold_q && !nrm_stall) begin
			cnt_q <= cnt_q + copy_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nrm_q <= dp_normal;
		end
	end

	assign nrm_valid         = hold_q;
	assign nrm_word.normal_x = nrm_q.x;
	assign nrm_word.normal_y = nrm_q.y;
	assign nrm_word.normal_z = nrm_q.z;
	assign nrm_word.last     = (cnt_q == LAST_COPY);

endmodule

/* hdl/tfn_datapath.sv */
// Pipelined cross product, sum of squares, bit-per-stage square root and division.
module tfn_datapath import tfn_pkg::*; #(
	parameter int COORD_BITS       = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  in_word_t in_word,
	output logic     out_valid,
	output normal_t  out_normal
);

	localparam int CB   = COORD_BITS;
	localparam int F    = NORMAL_FRAC_BITS;
	localparam int D    = CB + 1;
	localparam int PW   = 2 * D;
	localparam int CW   = PW + 1;
	localparam int M    = 2 * D;
	localparam int LB   = M / 2;
	localparam int HB   = M - LB;
	localparam int SQW  = 2 * M;
	localparam int SUMW = 2 * M + 2;
	localparam int SW   = M + 1;
	localparam int RW   = M + 2;
	localparam int QW   = F + 1;
	localparam int XW   = (QW > OUT_BITS ? QW : OUT_BITS) + 1;
	localparam int NST  = 6 + SW + QW + 1;

	typedef struct packed {
		logic [2:0][M-1:0] mag;
		logic [2:0]        neg;
		logic              zero;
	} carry_t;

	logic [NST-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[NST-1];

	logic [IN_BITS-1:0]         raw [9];
	logic signed [CB-1:0]       p   [9];
	logic signed [D-1:0]        e   [9];

	assign raw[0] = in_word.v0_x;
	assign raw[1] = in_word.v0_y;
	assign raw[2] = in_word.v0_z;
	assign raw[3] = in_word.v1_x;
	assign raw[4] = in_word.v1_y;
	assign raw[5] = in_word.v1_z;
	assign raw[6] = in_word.v2_x;
	assign raw[7] = in_word.v2_y;
	assign raw[8] = in_word.v2_z;

	for (genvar i = 0; i < 9; i++) begin : g_coord
		if (CB <= IN_BITS) begin : g_cut
			assign p[i] = raw[i][CB-1:0];
		end else begin : g_ext
			assign p[i] = {{(CB-IN_BITS){1'b0}}, raw[i]};
		end
		assign e[i] = {p[i][CB-1], p[i]};
	end

	logic signed [D-1:0] a_s1 [3];
	logic signed [D-1:0] b_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= e[k] - e[k+3];
				b_s1[k] <= e[k+6] - e[k+3];
			end
		end
	end

	logic signed [PW-1:0] pr_s2 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2[0] <= a_s1[1] * b_s1[2];
			pr_s2[1] <= a_s1[2] * b_s1[1];
			pr_s2[2] <= a_s1[2] * b_s1[0];
			pr_s2[3] <= a_s1[0] * b_s1[2];
			pr_s2[4] <= a_s1[0] * b_s1[1];
			pr_s2[5] <= a_s1[1] * b_s1[0];
		end
	end

	logic signed [CW-1:0] c    [3];
	logic        [CW-1:0] cabs [3];
	carry_t               cr_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c[k]    = {pr_s2[2*k][PW-1], pr_s2[2*k]} - {pr_s2[2*k+1][PW-1], pr_s2[2*k+1]};
			cabs[k] = c[k][CW-1] ? (-c[k]) : c[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				cr_s3.mag[k] <= cabs[k][M-1:0];
				cr_s3.neg[k] <= c[k][CW-1];
			end
			cr_s3.zero <= (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
		end
	end

	logic [2*HB-1:0]    hh_s4 [3];
	logic [HB+LB-1:0]   hl_s4 [3];
	logic [2*LB-1:0]    ll_s4 [3];
	carry_t             cr_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				hh_s4[k] <= cr_s3.mag[k][M-1:LB] * cr_s3.mag[k][M-1:LB];
				hl_s4[k] <= cr_s3.mag[k][M-1:LB] * cr_s3.mag[k][LB-1:0];
				ll_s4[k] <= cr_s3.mag[k][LB-1:0] * cr_s3.mag[k][LB-1:0];
			end
			cr_s4 <= cr_s3;
		end
	end

	logic [SQW-1:0] sq_s5 [3];
	carry_t         cr_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s5[k] <= (SQW'(hh_s4[k]) << (2 * LB)) + (SQW'(hl_s4[k]) << (LB + 1))
					+ SQW'(ll_s4[k]);
			end
			cr_s5 <= cr_s4;
		end
	end

	logic [SUMW-1:0] rr [0:SW];
	logic [SW-1:0]   ss [0:SW];
	carry_t          cr [0:SW];

	always_ff @(posedge clk) begin
		if (en) begin
			rr[0] <= SUMW'(sq_s5[0]) + SUMW'(sq_s5[1]) + SUMW'(sq_s5[2]);
			ss[0] <= '0;
			cr[0] <= cr_s5;
		end
	end

	for (genvar j = 0; j < SW; j++) begin : g_sqrt
		localparam int B = SW - 1 - j;
		logic [SUMW:0] dl;

		assign dl = ({{(SUMW+1-SW){1'b0}}, ss[j]} << (B + 1))
			+ ({{SUMW{1'b0}}, 1'b1} << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				cr[j+1] <= cr[j];
				if ({1'b0, rr[j]} >= dl) begin
					rr[j+1] <= rr[j] - dl[SUMW-1:0];
					ss[j+1] <= ss[j] | (SW'(1) << B);
				end else begin
					rr[j+1] <= rr[j];
					ss[j+1] <= ss[j];
				end
			end
		end
	end

	logic [2:0][RW-1:0] dr [1:QW];
	logic [2:0][QW-1:0] dq [1:QW];
	logic [SW-1:0]      ds [1:QW];
	carry_t             dc [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [2:0][RW-1:0] rin;
		logic [2:0][QW-1:0] qin;
		logic [RW-1:0]      sx;
		carry_t             cin;
		logic [2:0][RW-1:0] rnx;
		logic [2:0][QW-1:0] qnx;

		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rin[i] = {2'b00, cr[SW].mag[i]};
					qin[i] = '0;
				end
			end
			assign sx  = {1'b0, ss[SW]};
			assign cin = cr[SW];
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rin[i] = {dr[k][i][RW-2:0], 1'b0};
					qin[i] = dq[k][i];
				end
			end
			assign sx  = {1'b0, ds[k]};
			assign cin = dc[k];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				if (rin[i] >= sx) begin
					rnx[i] = rin[i] - sx;
					qnx[i] = {qin[i][QW-2:0], 1'b1};
				end else begin
					rnx[i] = rin[i];
					qnx[i] = {qin[i][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dr[k+1] <= rnx;
				dq[k+1] <= qnx;
				ds[k+1] <= sx[SW-1:0];
				dc[k+1] <= cin;
			end
		end
	end

	localparam logic [XW-1:0] LIM_POS = XW'((1 << (OUT_BITS - 1)) - 1);
	localparam logic [XW-1:0] LIM_NEG = XW'(1) << (OUT_BITS - 1);
	localparam logic [XW-1:0] UNIT    = XW'(1) << F;

	logic [XW-1:0]       qx  [3];
	logic [XW-1:0]       qm  [3];
	logic [OUT_BITS-1:0] res [3];
	logic [XW-1:0]       unit_sat;

	always_comb begin
		unit_sat = (UNIT > LIM_POS) ? LIM_POS : UNIT;
		for (int i = 0; i < 3; i++) begin
			qx[i] = XW'(dq[QW][i]);
			if (dc[QW].neg[i]) begin
				qm[i]  = (qx[i] > LIM_NEG) ? LIM_NEG : qx[i];
				res[i] = OUT_BITS'(-qm[i]);
			end else begin
				qm[i]  = (qx[i] > LIM_POS) ? LIM_POS : qx[i];
				res[i] = qm[i][OUT_BITS-1:0];
			end
		end
	end

	normal_t nrm_s;

	always_ff @(posedge clk) begin
		if (en) begin
			if (dc[QW].zero) begin
				nrm_s.x <= unit_sat[OUT_BITS-1:0];
				nrm_s.y <= '0;
				nrm_s.z <= '0;
			end else begin
				nrm_s.x <= res[0];
				nrm_s.y <= res[1];
				nrm_s.z <= res[2];
			end
		end
	end

	assign out_normal = nrm_s;

endmodule
